FILE: sv/bpmjc_pkg.sv
// shared types and constants for the brownout power-mode job controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bpmjc_pkg;

    localparam int MV_W       = 15;
    localparam int US_W       = 20;
    localparam int SUM_US_W   = US_W + 1;
    localparam int ID_W       = 16;
    localparam int TASK_W     = 8;
    localparam int POWER_W    = 15;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_OFF_MV     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_MV   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_MV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_US  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_MODE  = 3'd4;

    localparam logic [MV_W-1:0] RST_OFF_MV    = 15'd5500;
    localparam logic [MV_W-1:0] RST_SLEEP_MV  = 15'd5750;
    localparam logic [MV_W-1:0] RST_WAKE_MV   = 15'd6750;
    localparam logic [US_W-1:0] RST_PERIOD_US = 20'd22430;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CLAIM = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DONE   = 1'b1;

    localparam logic [POWER_W-1:0] POWER_OFF_MW    = 15'd0;
    localparam logic [POWER_W-1:0] POWER_LOW_MW    = 15'd500;
    localparam logic [POWER_W-1:0] POWER_DETECT_MW = 15'd22654;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_SLEEP  = 2'd1,
        MODE_IDLE   = 2'd2,
        MODE_DETECT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LOAD,
        ST_STEP,
        ST_REPORT,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic              operation;
        logic [US_W-1:0]   elapsed_us;
        logic [MV_W-1:0]   supply_mv;
        logic [ID_W-1:0]   job_id;
        logic [TASK_W-1:0] task_count;
    } item_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         mode;
        logic [POWER_W-1:0] power_mw;
        logic [ID_W-1:0]    done_job_id;
        logic [COUNT_W-1:0] queue_count;
        logic               claim_dropped;
        logic               last;
    } result_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic load;
        logic iterate;
        logic finish;
        logic emit_report;
        logic emit_status;
    } cmd_t;

    typedef struct packed {
        logic tick_detect;
        logic loop_go;
        logic pop;
        logic slot_free;
    } status_t;

    function automatic logic [POWER_W-1:0] mode_power(mode_t m);
        logic [POWER_W-1:0] p;
        unique case (m)
            MODE_OFF:    p = POWER_OFF_MW;
            MODE_SLEEP:  p = POWER_LOW_MW;
            MODE_IDLE:   p = POWER_LOW_MW;
            MODE_DETECT: p = POWER_DETECT_MW;
            default:     p = POWER_OFF_MW;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: sv/bpmjc_ctrl.sv
// controller state machine: sequences request capture, mode update, detect work
// loop and result emission; depends on bpmjc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpmjc_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               item_valid,
    output logic              item_ready,
    input  bpmjc_pkg::status_t status,
    output bpmjc_pkg::cmd_t   cmd
);
    import bpmjc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = status.tick_detect ? ST_LOAD : ST_STATUS;
            end
            ST_LOAD:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (status.loop_go)
                begin
                    state_next = status.pop ? ST_REPORT : ST_STEP;
                end
                else
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_REPORT:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_STATUS:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
            end
            ST_STEP:
            begin
                cmd.iterate = status.loop_go;
                cmd.finish  = !status.loop_go;
            end
            ST_REPORT:
            begin
                cmd.emit_report = status.slot_free;
            end
            ST_STATUS:
            begin
                cmd.emit_status = status.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/bpmjc_dp.sv
// datapath: config registers, mode and timer, job queue memory, result register
// depends on bpmjc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpmjc_dp #(
    parameter int JOB_DEPTH = 8
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  bpmjc_pkg::cmd_t                      cmd,
    output bpmjc_pkg::status_t                   status,
    input  bpmjc_pkg::item_t                     item,
    input  wire                                  cfg_write,
    input  wire [bpmjc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [bpmjc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 result_valid,
    input  wire                                  result_ready,
    output bpmjc_pkg::result_t                   result
);
    import bpmjc_pkg::*;

    localparam int IDX_W  = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int FILL_W = $clog2(JOB_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;

    logic [MV_W-1:0]   off_mv_reg;
    logic [MV_W-1:0]   sleep_mv_reg;
    logic [MV_W-1:0]   wake_mv_reg;
    logic [US_W-1:0]   period_reg;
    mode_t             init_mode_reg;

    mode_t             mode_reg;
    logic              started_reg;
    logic [US_W-1:0]   timer_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [FILL_W-1:0] fill_reg;

    item_t             item_reg;
    logic [SUM_US_W-1:0] t_reg;
    logic [TASK_W-1:0] tasks_rd_reg;
    logic [ID_W-1:0]   id_rd_reg;
    logic              dropped_reg;

    logic              result_valid_reg;
    result_t           result_reg;

    logic [ID_W-1:0]   ids_mem [JOB_DEPTH];
    logic [TASK_W-1:0] tasks_mem [JOB_DEPTH];

    mode_t             cur_mode;
    mode_t             wake_mode;
    mode_t             mode_next;
    logic              is_claim;
    logic              queue_full;
    logic              queue_busy;
    logic              below_off;
    logic              below_sleep;
    logic              at_wake;
    logic [SUM_W-1:0]  tail_sum;
    logic [IDX_W-1:0]  tail_idx;
    logic [IDX_W-1:0]  head_inc;
    logic [FILL_W+COUNT_W-1:0] fill_ext;
    logic              claim_write;
    logic              back_write;

    assign is_claim    = (item_reg.operation == OP_CLAIM);
    assign queue_full  = (fill_reg == FILL_W'(JOB_DEPTH));
    assign queue_busy  = (fill_reg != '0);
    assign below_off   = (item_reg.supply_mv < off_mv_reg);
    assign below_sleep = (item_reg.supply_mv < sleep_mv_reg);
    assign at_wake     = (item_reg.supply_mv >= wake_mv_reg);
    assign cur_mode    = started_reg ? mode_reg : init_mode_reg;
    assign wake_mode   = queue_busy ? MODE_DETECT : MODE_IDLE;

    assign tail_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign tail_idx = (tail_sum >= SUM_W'(JOB_DEPTH))
                      ? IDX_W'(tail_sum - SUM_W'(JOB_DEPTH))
                      : IDX_W'(tail_sum);
    assign head_inc = (head_reg == IDX_W'(JOB_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign fill_ext = {{COUNT_W{1'b0}}, fill_reg};

    assign claim_write = cmd.eval && is_claim && !queue_full;
    assign back_write  = cmd.finish && queue_busy;

    always_comb
    begin
        mode_next = cur_mode;
        unique case (cur_mode)
            MODE_OFF:
            begin
                if (at_wake)
                begin
                    mode_next = wake_mode;
                end
            end
            MODE_SLEEP:
            begin
                priority if (below_off)
                begin
                    mode_next = MODE_OFF;
                end
                else if (at_wake)
                begin
                    mode_next = wake_mode;
                end
            end
            MODE_IDLE:
            begin
                priority if (below_off)
                begin
                    mode_next = MODE_OFF;
                end
                else if (below_sleep)
                begin
                    mode_next = MODE_SLEEP;
                end
                else if (queue_busy)
                begin
                    mode_next = MODE_DETECT;
                end
            end
            MODE_DETECT:
            begin
                priority if (below_off)
                begin
                    mode_next = MODE_OFF;
                end
                else if (below_sleep)
                begin
                    mode_next = MODE_SLEEP;
                end
            end
            default:
            begin
                mode_next = cur_mode;
            end
        endcase
    end

    assign status.tick_detect = !is_claim && (cur_mode == MODE_DETECT)
                                && !below_off && !below_sleep;
    assign status.loop_go     = (t_reg >= SUM_US_W'(period_reg)) && queue_busy;
    assign status.pop         = (tasks_rd_reg <= TASK_W'(1));
    assign status.slot_free   = !result_valid_reg || result_ready;

    // config and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_mv_reg       <= RST_OFF_MV;
            sleep_mv_reg     <= RST_SLEEP_MV;
            wake_mv_reg      <= RST_WAKE_MV;
            period_reg       <= RST_PERIOD_US;
            init_mode_reg    <= MODE_OFF;
            mode_reg         <= MODE_OFF;
            started_reg      <= 1'b0;
            timer_reg        <= '0;
            head_reg         <= '0;
            fill_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_OFF_MV:    off_mv_reg    <= cfg_data[MV_W-1:0];
                    CFG_SLEEP_MV:  sleep_mv_reg  <= cfg_data[MV_W-1:0];
                    CFG_WAKE_MV:   wake_mv_reg   <= cfg_data[MV_W-1:0];
                    CFG_PERIOD_US: period_reg    <= cfg_data[US_W-1:0];
                    CFG_INIT_MODE: init_mode_reg <= mode_t'(cfg_data[1:0]);
                    default:       ;
                endcase
            end

            if (cmd.eval)
            begin
                if (is_claim)
                begin
                    if (!queue_full)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
                else
                begin
                    started_reg <= 1'b1;
                    mode_reg    <= mode_next;
                    if (cur_mode == MODE_DETECT && (below_off || below_sleep))
                    begin
                        timer_reg <= '0;
                    end
                end
            end

            if (cmd.iterate && status.pop)
            begin
                head_reg <= head_inc;
                fill_reg <= fill_reg - 1'b1;
            end

            if (cmd.finish)
            begin
                if (queue_busy)
                begin
                    timer_reg <= t_reg[US_W-1:0];
                end
                else
                begin
                    timer_reg <= '0;
                    mode_reg  <= MODE_IDLE;
                end
            end

            if (cmd.emit_report || cmd.emit_status)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end

        if (cmd.eval)
        begin
            dropped_reg <= is_claim && queue_full;
            t_reg       <= SUM_US_W'(timer_reg) + SUM_US_W'(item_reg.elapsed_us);
        end

        if (cmd.iterate)
        begin
            t_reg <= t_reg - SUM_US_W'(period_reg);
            if (!status.pop)
            begin
                tasks_rd_reg <= tasks_rd_reg - 1'b1;
            end
        end

        if (cmd.emit_report)
        begin
            result_reg.kind          <= KIND_DONE;
            result_reg.mode          <= mode_reg;
            result_reg.power_mw      <= mode_power(mode_reg);
            result_reg.done_job_id   <= id_rd_reg;
            result_reg.queue_count   <= fill_ext[COUNT_W-1:0];
            result_reg.claim_dropped <= 1'b0;
            result_reg.last          <= 1'b0;
        end
        else if (cmd.emit_status)
        begin
            result_reg.kind          <= KIND_STATUS;
            result_reg.mode          <= mode_reg;
            result_reg.power_mw      <= mode_power(mode_reg);
            result_reg.done_job_id   <= '0;
            result_reg.queue_count   <= fill_ext[COUNT_W-1:0];
            result_reg.claim_dropped <= dropped_reg;
            result_reg.last          <= 1'b1;
        end

        // queue memory: one write port, registered read at the head
        if (claim_write)
        begin
            ids_mem[tail_idx]   <= item_reg.job_id;
            tasks_mem[tail_idx] <= item_reg.task_count;
        end
        else if (back_write)
        begin
            tasks_mem[head_reg] <= tasks_rd_reg;
        end

        if (cmd.load)
        begin
            id_rd_reg    <= ids_mem[head_reg];
            tasks_rd_reg <= tasks_mem[head_reg];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

FILE: sv/brownout_power_mode_job_controller.sv
// Top level of the power-mode job controller: controller fsm plus datapath.
// Claim and non-detect tick: accept, evaluate, emit a status result, then idle again.
// Detect tick: accept, evaluate, load each head job, work off one task per cycle while
// a period is covered, a done result per job, then status; a stalled output adds its wait.
// Reset (async, rst_n low) restores register defaults, mode off, empty queue, cleared timer.
// Depends on bpmjc_pkg, bpmjc_ctrl, bpmjc_dp.
`timescale 1ns / 1ps
`default_nettype none

module brownout_power_mode_job_controller #(
    parameter int JOB_DEPTH = 8
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               item_valid,
    output logic                              item_ready,
    input  bpmjc_pkg::item_t                  item,
    output logic                              result_valid,
    input  wire                               result_ready,
    output bpmjc_pkg::result_t                result,
    input  wire                               cfg_write,
    input  wire [bpmjc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [bpmjc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bpmjc_pkg::*;

    cmd_t    cmd;
    status_t status;

    bpmjc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    bpmjc_dp #(
        .JOB_DEPTH (JOB_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire
